>>> src/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clk, disabled in reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> src/tfs_pkg.sv
// ------------------------------------------------------------------------
// tfs_pkg
// codes and constants of the thermostat with fan scheduler
// ------------------------------------------------------------------------
package tfs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TEMP_W     = 15;
    localparam int SEC_W      = 23;

    localparam int HYST     = 50;
    localparam int MS_PER_S = 1000;

    // mode codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_HEAT  = 2'd1;
    localparam logic [1:0] MODE_COOL  = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_INT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_DUR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_EN    = 3'd5;

endpackage

>>> src/tfs_regs.sv
// ------------------------------------------------------------------------
// tfs_regs
// configuration registers; time limits kept in ms, clamped to the time range
// ------------------------------------------------------------------------
module tfs_regs
    import tfs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic signed [TEMP_W-1:0]    threshold,
    output logic [TIME_BITS-1:0]        heat_lim,
    output logic [TIME_BITS-1:0]        cool_lim,
    output logic [TIME_BITS-1:0]        fan_int_lim,
    output logic [TIME_BITS-1:0]        fan_dur_lim,
    output logic                        fan_enable
);

    localparam int CW = (TIME_BITS > 33) ? TIME_BITS : 33;

    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [32:0] x);
        logic [CW-1:0] wide;
        logic [CW-1:0] tmask;
        begin
            wide  = CW'(x);
            tmask = CW'({TIME_BITS{1'b1}});
            clamp_time = (wide > tmask) ? {TIME_BITS{1'b1}} : TIME_BITS'(wide);
        end
    endfunction

    logic signed [TEMP_W-1:0]  threshold_reg;
    logic [TIME_BITS-1:0]      heat_lim_reg;
    logic [TIME_BITS-1:0]      cool_lim_reg;
    logic [TIME_BITS-1:0]      fan_int_lim_reg;
    logic [TIME_BITS-1:0]      fan_dur_lim_reg;
    logic                      fan_enable_reg;
    logic [32:0]               sec_ms;

    // seconds to ms
    assign sec_ms = 33'(cfg_data[SEC_W-1:0]) * 33'(MS_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= 15'sd2000;
            heat_lim_reg    <= clamp_time(33'd600000);
            cool_lim_reg    <= clamp_time(33'd300000);
            fan_int_lim_reg <= clamp_time(33'd3600000);
            fan_dur_lim_reg <= clamp_time(33'd300000);
            fan_enable_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg   <= signed'(cfg_data[TEMP_W-1:0]);
                REG_HEAT_MAX:  heat_lim_reg    <= clamp_time({1'b0, cfg_data});
                REG_COOLDOWN:  cool_lim_reg    <= clamp_time({1'b0, cfg_data});
                REG_FAN_INT:   fan_int_lim_reg <= clamp_time(sec_ms);
                REG_FAN_DUR:   fan_dur_lim_reg <= clamp_time(sec_ms);
                REG_FAN_EN:    fan_enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign threshold   = threshold_reg;
    assign heat_lim    = heat_lim_reg;
    assign cool_lim    = cool_lim_reg;
    assign fan_int_lim = fan_int_lim_reg;
    assign fan_dur_lim = fan_dur_lim_reg;
    assign fan_enable  = fan_enable_reg;

endmodule

>>> src/thermostat_with_fan_scheduler.sv
// ------------------------------------------------------------------------
// thermostat_with_fan_scheduler
// bang-bang thermostat with hysteresis, fault latch and periodic fan runs
// ------------------------------------------------------------------------
// channel   direction  handshake             word
// in        input      in_valid / in_ready   now_ms, temp_centi_c, sensor_ok
// out       output     out_valid / out_ready heater_drive, fan_drive,
//                                            mode_now, watchdog_feed
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while out_ready holds; a word passes the input
// register, then one pass of compare logic into the result register
// state updates when a word moves from the input register to the result
// register, so back-to-back words see each other's state
// a stalled result holds the result register; an empty input register fills
// reset gives idle mode, fan off, zero time marks and default registers
// ------------------------------------------------------------------------
module thermostat_with_fan_scheduler
    import tfs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               now_ms,
    input  logic signed [TEMP_W-1:0]  temp_centi_c,
    input  logic                      sensor_ok,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      heater_drive,
    output logic                      fan_drive,
    output logic [1:0]                mode_now,
    output logic                      watchdog_feed,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [1:0]
    {
        ST_IDLE  = MODE_IDLE,
        ST_HEAT  = MODE_HEAT,
        ST_COOL  = MODE_COOL,
        ST_FAULT = MODE_FAULT
    } mode_state_t;

    typedef logic [TIME_BITS-1:0] time_t;

    function automatic time_t elapsed(input time_t now, input time_t since);
        begin
            elapsed = now - since;
        end
    endfunction

    logic signed [TEMP_W-1:0] threshold;
    time_t                    heat_lim;
    time_t                    cool_lim;
    time_t                    fan_int_lim;
    time_t                    fan_dur_lim;
    logic                     fan_enable;

    tfs_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .threshold   (threshold),
        .heat_lim    (heat_lim),
        .cool_lim    (cool_lim),
        .fan_int_lim (fan_int_lim),
        .fan_dur_lim (fan_dur_lim),
        .fan_enable  (fan_enable)
    );

    assign cfg_ready = 1'b1;

    // input register
    logic                     s1_valid_reg, s1_valid_next;
    logic [31:0]              s1_now_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s1_ok_reg;

    // thermostat and fan state
    mode_state_t mode_reg, mode_next;
    time_t       mode_start_reg, mode_start_next;
    logic        fault_heat_reg, fault_heat_next;
    logic        fan_active_reg, fan_active_next;
    time_t       fan_start_reg, fan_start_next;
    time_t       fan_last_reg, fan_last_next;
    logic        fan_deferred_reg, fan_deferred_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        heater_reg;
    logic        fan_reg;
    logic [1:0]  mode_out_reg;
    logic        feed_reg, feed_next;

    logic                      advance;
    logic                      in_take;
    time_t                     now_t;
    logic                      take_sample;
    logic signed [TEMP_W:0]    thr_low;
    logic signed [TEMP_W:0]    temp_ext;

    assign advance  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | advance;
    assign in_take  = in_valid & in_ready;

    assign s1_valid_next  = in_take | (s1_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~out_ready);

    assign now_t    = TIME_BITS'(s1_now_reg);
    assign thr_low  = {threshold[TEMP_W-1], threshold} - (TEMP_W+1)'(HYST);
    assign temp_ext = {s1_temp_reg[TEMP_W-1], s1_temp_reg};

    always_comb
    begin
        mode_next         = mode_reg;
        mode_start_next   = mode_start_reg;
        fault_heat_next   = fault_heat_reg;
        fan_active_next   = fan_active_reg;
        fan_start_next    = fan_start_reg;
        fan_last_next     = fan_last_reg;
        fan_deferred_next = fan_deferred_reg;
        feed_next         = 1'b0;
        take_sample       = 1'b1;

        if (mode_reg != ST_FAULT)
        begin
            // heating time-out comes before the sample
            if (mode_reg == ST_HEAT && elapsed(now_t, mode_start_reg) >= heat_lim)
            begin
                mode_next       = ST_COOL;
                mode_start_next = now_t;
                take_sample     = 1'b0;
            end

            if (take_sample && !s1_ok_reg)
            begin
                fault_heat_next = (mode_reg == ST_HEAT);
                mode_next       = ST_FAULT;
            end
            else if (take_sample)
            begin
                feed_next = 1'b1;
                case (mode_reg)
                    ST_IDLE:
                    begin
                        if (temp_ext <= thr_low && !fan_active_reg)
                        begin
                            mode_next       = ST_HEAT;
                            mode_start_next = now_t;
                        end
                    end
                    ST_HEAT:
                    begin
                        if (s1_temp_reg >= threshold)
                        begin
                            mode_next       = ST_COOL;
                            mode_start_next = now_t;
                        end
                    end
                    default:
                    begin
                        if (elapsed(now_t, mode_start_reg) >= cool_lim)
                        begin
                            mode_next       = ST_IDLE;
                            mode_start_next = now_t;
                        end
                    end
                endcase
            end

            if (mode_next != ST_FAULT)
            begin
                if (!fan_enable)
                begin
                    fan_active_next   = 1'b0;
                    fan_deferred_next = 1'b0;
                    fan_last_next     = now_t;
                end
                else if (fan_active_reg)
                begin
                    if (elapsed(now_t, fan_start_reg) >= fan_dur_lim)
                    begin
                        fan_active_next = 1'b0;
                        fan_last_next   = now_t;
                    end
                end
                else if (fan_deferred_reg)
                begin
                    if (mode_next != ST_HEAT)
                    begin
                        fan_active_next   = 1'b1;
                        fan_start_next    = now_t;
                        fan_deferred_next = 1'b0;
                    end
                end
                else if (elapsed(now_t, fan_last_reg) >= fan_int_lim)
                begin
                    if (mode_next == ST_HEAT)
                    begin
                        fan_deferred_next = 1'b1;
                    end
                    else
                    begin
                        fan_active_next = 1'b1;
                        fan_start_next  = now_t;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_now_reg       <= '0;
            s1_temp_reg      <= '0;
            s1_ok_reg        <= 1'b0;
            mode_reg         <= ST_IDLE;
            mode_start_reg   <= '0;
            fault_heat_reg   <= 1'b0;
            fan_active_reg   <= 1'b0;
            fan_start_reg    <= '0;
            fan_last_reg     <= '0;
            fan_deferred_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            heater_reg       <= 1'b0;
            fan_reg          <= 1'b0;
            mode_out_reg     <= MODE_IDLE;
            feed_reg         <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_take)
            begin
                s1_now_reg  <= now_ms;
                s1_temp_reg <= temp_centi_c;
                s1_ok_reg   <= sensor_ok;
            end
            if (advance)
            begin
                mode_reg         <= mode_next;
                mode_start_reg   <= mode_start_next;
                fault_heat_reg   <= fault_heat_next;
                fan_active_reg   <= fan_active_next;
                fan_start_reg    <= fan_start_next;
                fan_last_reg     <= fan_last_next;
                fan_deferred_reg <= fan_deferred_next;
                heater_reg       <= (mode_next == ST_HEAT) ||
                                    (mode_next == ST_FAULT && fault_heat_next);
                fan_reg          <= fan_active_next;
                mode_out_reg     <= mode_next;
                feed_reg         <= feed_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign heater_drive  = heater_reg;
    assign fan_drive     = fan_reg;
    assign mode_now      = mode_out_reg;
    assign watchdog_feed = feed_reg;

endmodule

>>> src/tfs_checker.sv
// ------------------------------------------------------------------------
// tfs_checker
// port-level checks of the thermostat with fan scheduler, bound to the top
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module tfs_checker
    import tfs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       heater_drive,
    input logic       fan_drive,
    input logic [1:0] mode_now,
    input logic       watchdog_feed
);

    // stalled result word holds
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode_now) && $stable(heater_drive) && $stable(fan_drive) && $stable(watchdog_feed))

    // heater follows mode outside fault
    `CHK_SAME(a_heat_on, out_valid && mode_now == MODE_HEAT, heater_drive)
    `CHK_SAME(a_heat_off, out_valid && (mode_now == MODE_IDLE || mode_now == MODE_COOL), !heater_drive)

    // no watchdog feed in fault
    `CHK_SAME(a_fault_feed, out_valid && mode_now == MODE_FAULT, !watchdog_feed)

endmodule

bind thermostat_with_fan_scheduler tfs_checker u_tfs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .heater_drive  (heater_drive),
    .fan_drive     (fan_drive),
    .mode_now      (mode_now),
    .watchdog_feed (watchdog_feed)
);
